### rtl/gci_pkg.sv
`timescale 1ns / 1ps
// Shared types, turn constants and the CORDIC arctangent table for the great-circle solver.
// No dependencies.
package gci_pkg;

    typedef logic [63:0] turn_t;
    typedef logic signed [63:0] q58_t;

    localparam q58_t  KQ           = 64'sd175028741876840809;
    localparam turn_t INV_PI_Q64   = 64'h517CC1B727220A95;
    localparam turn_t HALF_TURN    = 64'h8000000000000000;
    localparam turn_t QUARTER_TURN = 64'h4000000000000000;

    function automatic turn_t atan_entry(input int idx);
        turn_t        pos;
        turn_t        negs;
        turn_t        num;
        turn_t        den;
        turn_t        rem;
        turn_t        term;
        logic [127:0] prod;
        int           e;
        pos  = '0;
        negs = '0;
        if (idx == 0)
        begin
            return turn_t'(1) << 61;
        end
        for (int k = 0; k < 32; k++)
        begin
            e = idx * (2 * k + 1);
            if (e <= 63)
            begin
                // long division by shift and subtract
                num  = turn_t'(1) << (63 - e);
                den  = turn_t'(2 * k + 1);
                rem  = '0;
                term = '0;
                for (int b = 63; b >= 0; b--)
                begin
                    rem  = {rem[62:0], num[b]};
                    term = {term[62:0], 1'b0};
                    if (rem >= den)
                    begin
                        rem     = rem - den;
                        term[0] = 1'b1;
                    end
                end
                if (k[0])
                begin
                    negs = negs + term;
                end
                else
                begin
                    pos = pos + term;
                end
            end
        end
        prod = {64'd0, pos - negs} * {64'd0, INV_PI_Q64};
        return prod[127:64];
    endfunction

endpackage

### rtl/gci_fmul.sv
`timescale 1ns / 1ps
// Four-stage signed Q58 multiplier, truncating toward zero, built from 32x32 partial products.
// Depends on gci_pkg.
module gci_fmul
    import gci_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  q58_t a,
    input  q58_t b,
    output q58_t p
);

    logic         neg_s1_reg;
    logic         neg_s2_reg;
    logic         neg_s3_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic [63:0]  ll_reg;
    logic [63:0]  lh_reg;
    logic [63:0]  hl_reg;
    logic [63:0]  hh_reg;
    logic [127:0] prod_reg;
    q58_t         p_reg;
    logic [63:0]  mag;

    assign mag = {1'b0, prod_reg[120:58]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_s1_reg <= a[63] ^ b[63];
            ua_reg     <= a[63] ? 64'(-a) : 64'(a);
            ub_reg     <= b[63] ? 64'(-b) : 64'(b);
            neg_s2_reg <= neg_s1_reg;
            ll_reg     <= 64'(ua_reg[31:0]) * 64'(ub_reg[31:0]);
            lh_reg     <= 64'(ua_reg[31:0]) * 64'(ub_reg[63:32]);
            hl_reg     <= 64'(ua_reg[63:32]) * 64'(ub_reg[31:0]);
            hh_reg     <= 64'(ua_reg[63:32]) * 64'(ub_reg[63:32]);
            neg_s3_reg <= neg_s2_reg;
            prod_reg   <= {hh_reg, 64'd0} + {32'd0, lh_reg, 32'd0}
                        + {32'd0, hl_reg, 32'd0} + {64'd0, ll_reg};
            p_reg      <= neg_s3_reg ? -q58_t'(mag) : q58_t'(mag);
        end
    end

    assign p = p_reg;

endmodule

### rtl/great_circle_inverse.sv
`timescale 1ns / 1ps
// Great-circle inverse solver: sin/cos CORDIC, frame rotation, two atan2 CORDIC passes.
// Depends on gci_pkg and gci_fmul.
//
//  channel  dir  payload (lowest bits first)
//  s_*      in   start_lat, start_lon, end_lat, end_lon (ANGLE_BITS each)
//  m_*      out  azimuth, distance (ANGLE_BITS each)
//
// One transaction per cycle while the skid register is empty; the path from input transaction
// to m_tvalid runs through the three chained CORDIC chains of ANGLE_BITS+4 iterations and the
// multiplier stages.
// Reset clears the valid bits and the output/skid flags only.
// A full skid register freezes the pipeline; nothing is lost or repeated.
module great_circle_inverse
    import gci_pkg::*;
#(
    parameter int ANGLE_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // start_lat, start_lon, end_lat, end_lon
    input  logic [((4 * ANGLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // azimuth, distance
    output logic [((2 * ANGLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int    N        = ANGLE_BITS + 4;
    localparam int    SH       = 64 - ANGLE_BITS;
    localparam int    OUT_W    = ((2 * ANGLE_BITS + 7) / 8) * 8;
    localparam int    LAT      = 3 * N + 18;
    localparam turn_t HALF_LSB = turn_t'(1) << (SH - 1);

    logic en;
    logic arrive;
    logic out_free;
    logic [LAT-1:0] vld_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic [ANGLE_BITS-1:0] azimuth_reg;
    logic [ANGLE_BITS-1:0] distance_reg;
    logic [2*ANGLE_BITS-1:0] out_data_reg;
    logic [2*ANGLE_BITS-1:0] skid_data_reg;

    turn_t th [3];
    q58_t  sc_x_reg [3][N+1];
    q58_t  sc_y_reg [3][N+1];
    turn_t sc_z_reg [3][N+1];
    logic  sc_f_reg [3][N+1];
    q58_t  cs_c_reg [3];
    q58_t  cs_s_reg [3];

    q58_t x0;
    q58_t x1;
    q58_t pa;
    q58_t pb;
    q58_t pc;
    q58_t pd;
    q58_t p;
    q58_t x2d_reg [4];
    q58_t cl1d_reg [4];
    q58_t sl1d_reg [4];
    q58_t x1d_reg [4];
    q58_t r2_reg;
    q58_t r0_reg;
    q58_t x1f_reg;
    q58_t r2d_reg [N+5];
    turn_t lonr_d_reg [N+5];

    q58_t  at_in_x [2];
    q58_t  at_in_y [2];
    q58_t  at_x_reg [2][N+1];
    q58_t  at_y_reg [2][N+1];
    turn_t at_z_reg [2][N+1];
    logic  at_zero_reg [2][N+1];

    turn_t lonr;
    turn_t el;
    turn_t azi;
    turn_t arc;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign arrive   = en && vld_reg[LAT-1];
    assign out_free = !out_valid_reg || m_tready;

    assign th[0] = {s_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS], SH'(0)};
    assign th[1] = {s_tdata[4*ANGLE_BITS-1:3*ANGLE_BITS], SH'(0)}
                 - {s_tdata[2*ANGLE_BITS-1:ANGLE_BITS], SH'(0)};
    assign th[2] = {s_tdata[ANGLE_BITS-1:0], SH'(0)};

    // sin/cos CORDIC lanes: end latitude, longitude difference, start latitude
    for (genvar l = 0; l < 3; l++)
    begin : g_sc
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sc_x_reg[l][0] <= KQ;
                sc_y_reg[l][0] <= '0;
                sc_z_reg[l][0] <= {th[l][62], th[l][62:0]};
                sc_f_reg[l][0] <= th[l][63] ^ th[l][62];
            end
        end
        for (genvar i = 0; i < N; i++)
        begin : g_it
            localparam turn_t T = atan_entry(i);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sc_f_reg[l][i+1] <= sc_f_reg[l][i];
                    if (!sc_z_reg[l][i][63])
                    begin
                        sc_x_reg[l][i+1] <= sc_x_reg[l][i] - (sc_y_reg[l][i] >>> i);
                        sc_y_reg[l][i+1] <= sc_y_reg[l][i] + (sc_x_reg[l][i] >>> i);
                        sc_z_reg[l][i+1] <= sc_z_reg[l][i] - T;
                    end
                    else
                    begin
                        sc_x_reg[l][i+1] <= sc_x_reg[l][i] + (sc_y_reg[l][i] >>> i);
                        sc_y_reg[l][i+1] <= sc_y_reg[l][i] - (sc_x_reg[l][i] >>> i);
                        sc_z_reg[l][i+1] <= sc_z_reg[l][i] + T;
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cs_c_reg[l] <= sc_f_reg[l][N] ? -sc_x_reg[l][N] : sc_x_reg[l][N];
                cs_s_reg[l] <= sc_f_reg[l][N] ? -sc_y_reg[l][N] : sc_y_reg[l][N];
            end
        end
    end

    gci_fmul u_x0 (.clk(clk), .en(en), .a(cs_c_reg[0]), .b(cs_c_reg[1]), .p(x0));
    gci_fmul u_x1 (.clk(clk), .en(en), .a(cs_c_reg[0]), .b(cs_s_reg[1]), .p(x1));

    gci_fmul u_pa (.clk(clk), .en(en), .a(x2d_reg[3]), .b(sl1d_reg[3]), .p(pa));
    gci_fmul u_pb (.clk(clk), .en(en), .a(x0), .b(cl1d_reg[3]), .p(pb));
    gci_fmul u_pc (.clk(clk), .en(en), .a(x0), .b(sl1d_reg[3]), .p(pc));
    gci_fmul u_pd (.clk(clk), .en(en), .a(x2d_reg[3]), .b(cl1d_reg[3]), .p(pd));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2d_reg[0]  <= cs_s_reg[0];
            cl1d_reg[0] <= cs_c_reg[2];
            sl1d_reg[0] <= cs_s_reg[2];
            x1d_reg[0]  <= x1;
            for (int j = 1; j < 4; j++)
            begin
                x2d_reg[j]  <= x2d_reg[j-1];
                cl1d_reg[j] <= cl1d_reg[j-1];
                sl1d_reg[j] <= sl1d_reg[j-1];
                x1d_reg[j]  <= x1d_reg[j-1];
            end
            r2_reg  <= pa + pb;
            r0_reg  <= pc - pd;
            x1f_reg <= x1d_reg[3];
            r2d_reg[0]    <= r2_reg;
            lonr_d_reg[0] <= lonr;
            for (int j = 1; j < N + 5; j++)
            begin
                r2d_reg[j]    <= r2d_reg[j-1];
                lonr_d_reg[j] <= lonr_d_reg[j-1];
            end
        end
    end

    assign at_in_y[0] = x1f_reg;
    assign at_in_x[0] = r0_reg;
    assign at_in_y[1] = r2d_reg[N+4];
    assign at_in_x[1] = p;

    // atan2 CORDIC units: longitude in the rotated frame, then elevation
    for (genvar u = 0; u < 2; u++)
    begin : g_at
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                at_zero_reg[u][0] <= (at_in_x[u] == '0) && (at_in_y[u] == '0);
                if (at_in_x[u][63])
                begin
                    at_x_reg[u][0] <= -at_in_x[u];
                    at_y_reg[u][0] <= -at_in_y[u];
                    at_z_reg[u][0] <= HALF_TURN;
                end
                else
                begin
                    at_x_reg[u][0] <= at_in_x[u];
                    at_y_reg[u][0] <= at_in_y[u];
                    at_z_reg[u][0] <= '0;
                end
            end
        end
        for (genvar i = 0; i < N; i++)
        begin : g_it
            localparam turn_t T = atan_entry(i);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    at_zero_reg[u][i+1] <= at_zero_reg[u][i];
                    if (!at_y_reg[u][i][63])
                    begin
                        at_x_reg[u][i+1] <= at_x_reg[u][i] + (at_y_reg[u][i] >>> i);
                        at_y_reg[u][i+1] <= at_y_reg[u][i] - (at_x_reg[u][i] >>> i);
                        at_z_reg[u][i+1] <= at_z_reg[u][i] + T;
                    end
                    else
                    begin
                        at_x_reg[u][i+1] <= at_x_reg[u][i] - (at_y_reg[u][i] >>> i);
                        at_y_reg[u][i+1] <= at_y_reg[u][i] + (at_x_reg[u][i] >>> i);
                        at_z_reg[u][i+1] <= at_z_reg[u][i] - T;
                    end
                end
            end
        end
    end

    assign lonr = at_zero_reg[0][N] ? '0 : at_z_reg[0][N];

    gci_fmul u_gain (.clk(clk), .en(en), .a(at_x_reg[0][N]), .b(KQ), .p(p));

    always_comb
    begin
        el = at_zero_reg[1][N] ? '0 : at_z_reg[1][N];
        if (!el[63])
        begin
            if (el > QUARTER_TURN)
            begin
                el = QUARTER_TURN;
            end
        end
        else if (el < (64'd0 - QUARTER_TURN))
        begin
            el = 64'd0 - QUARTER_TURN;
        end
        azi = HALF_TURN - lonr_d_reg[N+4] + HALF_LSB;
        arc = QUARTER_TURN - el + HALF_LSB;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            azimuth_reg  <= azi[63:SH];
            distance_reg <= arc[63:SH];
        end
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : {distance_reg, azimuth_reg};
        end
        else if (arrive)
        begin
            skid_data_reg <= {distance_reg, azimuth_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= arrive;
                end
            end
            else if (arrive)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for great_circle_inverse: table-driven directed pairs, then random tracks.
// Depends on gci_pkg and the great_circle_inverse RTL.
module tb_top;
    import gci_pkg::*;

    localparam int AB     = 32;
    localparam int ITERS  = AB + 4;
    localparam int LAT    = 3 * ITERS + 19;
    localparam int NRAND  = 1800;
    localparam int LIMIT  = 2000000;

    typedef struct packed {
        logic signed [31:0] end_lon;
        logic signed [31:0] end_lat;
        logic signed [31:0] start_lon;
        logic signed [31:0] start_lat;
    } leg_t;

    typedef struct packed {
        logic [31:0] distance;
        logic [31:0] azimuth;
    } bearing_t;

    typedef struct {
        leg_t     leg;
        logic     known;
        bearing_t want;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;

    turn_t    atan_tab [ITERS];
    bearing_t bearing_q [$];
    row_t     rows [$];
    int       errors;
    int       checked;
    int       sent;
    longint   cycles;
    bit       hold_rx;

    great_circle_inverse #(.ANGLE_BITS(AB)) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic q58_t asr(q58_t v, int n);
        return v >>> n;
    endfunction

    function automatic q58_t qmul(q58_t a, q58_t b);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = {64'd0, ua} * {64'd0, ub};
        r   = p[121:58] & 64'h7FFFFFFFFFFFFFFF;
        return neg ? -q58_t'(r) : q58_t'(r);
    endfunction

    task automatic rotate_sincos(input turn_t th, output q58_t c, output q58_t s);
        logic  flip;
        q58_t  x;
        q58_t  y;
        q58_t  dx;
        q58_t  dy;
        turn_t z;
        flip = (th[63:62] == 2'd1) || (th[63:62] == 2'd2);
        x = KQ;
        y = 0;
        z = flip ? th + HALF_TURN : th;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (!z[63])
            begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic vector_atan2(input q58_t yi, input q58_t xi, output turn_t ang,
                                output q58_t mag);
        q58_t  x;
        q58_t  y;
        q58_t  dx;
        q58_t  dy;
        turn_t z;
        x = xi;
        y = yi;
        z = '0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            ang = '0;
            return;
        end
        if (x < 0)
        begin
            x = -x; y = -y; z = HALF_TURN;
        end
        for (int i = 0; i < ITERS; i++)
        begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
        end
        mag = x;
        ang = z;
    endtask

    task automatic solve_leg(input leg_t g, output bearing_t b);
        turn_t lat1, lon1, lat2, lon2, lonr, el, azi, arc;
        q58_t  cl1, sl1, cl2, sl2, cd, sd, x0, x1, x2, r0, r2, gm, p, spare;
        lat1 = {g.start_lat, 32'd0};
        lon1 = {g.start_lon, 32'd0};
        lat2 = {g.end_lat, 32'd0};
        lon2 = {g.end_lon, 32'd0};
        rotate_sincos(lat2, cl2, sl2);
        rotate_sincos(lon2 - lon1, cd, sd);
        rotate_sincos(lat1, cl1, sl1);
        x0 = qmul(cl2, cd);
        x1 = qmul(cl2, sd);
        x2 = sl2;
        r2 = qmul(x2, sl1) + qmul(x0, cl1);
        r0 = qmul(x0, sl1) - qmul(x2, cl1);
        vector_atan2(x1, r0, lonr, gm);
        p = qmul(gm, KQ);
        vector_atan2(r2, p, el, spare);
        if (!el[63])
        begin
            if (el > QUARTER_TURN)
            begin
                el = QUARTER_TURN;
            end
        end
        else if (el < -QUARTER_TURN)
        begin
            el = -QUARTER_TURN;
        end
        azi = HALF_TURN - lonr;
        arc = QUARTER_TURN - el;
        azi = azi + 64'h80000000;
        arc = arc + 64'h80000000;
        b.azimuth  = azi[63:32];
        b.distance = arc[63:32];
    endtask

    function automatic logic [31:0] rand_lat();
        return 32'(int'($urandom_range(32'h80000000)) - 32'sh40000000);
    endfunction

    function automatic int rand_gap();
        return ($urandom_range(9) == 0) ? $urandom_range(40) :
               (($urandom_range(3) == 0) ? $urandom_range(3) : 0);
    endfunction

    task automatic add_row(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d);
        row_t r;
        r.leg.start_lat = a;
        r.leg.start_lon = b;
        r.leg.end_lat   = c;
        r.leg.end_lon   = d;
        r.known         = 1'b0;
        r.want          = '0;
        rows.push_back(r);
    endtask

    task automatic add_known(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d,
                             input logic [31:0] azm, input logic [31:0] dst);
        add_row(a, b, c, d);
        rows[$].known = 1'b1;
        rows[$].want  = '{distance: dst, azimuth: azm};
    endtask

    task automatic send_leg(input leg_t g, input row_t r);
        bearing_t b;
        int       gap;
        solve_leg(g, b);
        if (r.known && b != r.want)
        begin
            $display("%0t table row mismatch: expected %h actual model %h", $time, r.want, b);
            errors++;
        end
        gap = rand_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= g;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        bearing_q.push_back(b);
        sent++;
    endtask

    task automatic idle_in();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        bearing_t got;
        bearing_t exp_b;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (bearing_q.size() == 0)
            begin
                $display("%0t unexpected result: actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_b = bearing_q.pop_front();
                checked++;
                if (got.azimuth !== exp_b.azimuth)
                begin
                    $display("%0t azimuth: expected %h actual %h", $time, exp_b.azimuth,
                             got.azimuth);
                    errors++;
                end
                if (got.distance !== exp_b.distance)
                begin
                    $display("%0t distance: expected %h actual %h", $time, exp_b.distance,
                             got.distance);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_rx || $urandom_range(7) == 0)
        begin
            m_tready <= 1'b0;
        end
        else if ($urandom_range(60) == 0)
        begin
            m_tready <= 1'b0;
            hold_rx  = 1'b1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
        if (hold_rx && $urandom_range(25) == 0)
        begin
            hold_rx = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout, %0d results outstanding", $time, bearing_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        row_t r;
        leg_t g;
        int   tail;
        errors   = 0;
        checked  = 0;
        sent     = 0;
        cycles   = 0;
        hold_rx  = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        for (int i = 0; i < ITERS; i++)
        begin
            atan_tab[i] = atan_entry(i);
        end

        // coincident, pole-to-pole and antipodal legs: azimuth follows the rounding residue
        add_row(32'h0, 32'h0, 32'h0, 32'h0);
        add_row(32'h40000000, 32'h0, 32'hC0000000, 32'h0);
        add_row(32'hC0000000, 32'h7FFFFFFF, 32'h40000000, 32'h80000000);
        add_row(32'h0, 32'h0, 32'h0, 32'h80000000);
        // quarter turn east along the equator, then assorted directed legs
        add_known(32'h0, 32'h0, 32'h0, 32'h40000000, 32'h40000000, 32'h40000000);
        add_row(32'h0, 32'h0, 32'h40000000, 32'h0);
        add_row(32'h0, 32'h0, 32'hC0000000, 32'h0);
        add_row(32'h40000000, 32'h12345678, 32'h40000000, 32'h9ABCDEF0);
        add_row(32'h20000000, 32'h80000000, 32'hE0000000, 32'h7FFFFFFF);
        add_row(32'h7FFFFFFF, 32'h0, 32'h80000000, 32'hFFFFFFFF);
        add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001, 32'h00000001);
        add_row(32'h15555555, 32'h2AAAAAAA, 32'h15555555, 32'h2AAAAAAB);
        add_row(32'h3FFFFFFF, 32'h55555555, 32'hC0000001, 32'hAAAAAAAA);
        add_row(32'h10000000, 32'h0, 32'hF0000000, 32'h80000000);
        add_row(32'h2D000000, 32'hF0000000, 32'h2E000000, 32'hF1000000);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            send_leg(rows[i].leg, rows[i]);
        end

        // drain before the random part
        idle_in();
        wait (bearing_q.size() == 0);

        r.known = 1'b0;
        r.want  = '0;
        for (int n = 0; n < NRAND; n++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    g = {$urandom, $urandom, $urandom, $urandom};
                end
                1, 2:
                begin
                    g.start_lat = rand_lat();
                    g.start_lon = $urandom;
                    g.end_lat   = g.start_lat + 32'($urandom_range(511)) - 256;
                    g.end_lon   = ($urandom_range(1)) ? g.start_lon + 32'($urandom_range(511))
                                  - 256 : g.start_lon + 32'h80000000;
                end
                default:
                begin
                    g.start_lat = rand_lat();
                    g.start_lon = $urandom;
                    g.end_lat   = rand_lat();
                    g.end_lon   = $urandom;
                end
            endcase
            send_leg(g, r);
            if (n == NRAND / 2)
            begin
                idle_in();
                wait (bearing_q.size() == 0);
            end
        end

        idle_in();
        wait (bearing_q.size() == 0);
        tail = 0;
        while (tail < 4 * LAT)
        begin
            @(posedge clk);
            tail++;
        end
        $display("Sent %0d point pairs (directed table and random legs); %0d results checked.",
                 sent, checked);
        if (errors == 0 && bearing_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
